// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset masks the check.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication failed");

// Next-cycle implication, reset masks the check.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication failed");

`endif

// ===== rtl/hlhc_pkg.sv =====
// Types, constants and lookup tables of the heater and lamp controller.
`timescale 1ns / 1ps

package hlhc_pkg;

    localparam int TABLE_ROWS = 10;

    localparam int CODE_W   = 12;
    localparam int TEMP_W   = 9;
    localparam int OHMS_W   = 24;
    localparam int LUX_W    = 10;
    localparam int DIV_R_W  = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_AUTO_MODE      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEAT_ON_BELOW  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEAT_OFF_ABOVE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LAMP_ON_BELOW  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LAMP_OFF_ABOVE = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIVIDER_OHMS   = 3'd5;

    // temperature = floor(code * 330 / 4095), same as the two-step /4095 then /10
    localparam int TEMP_SCALE = 330;
    localparam int ADC_FULL   = 4095;

    localparam int TEMP_DIVIDEND_W  = 21;
    localparam int LIGHT_DIVIDEND_W = 28;

    localparam logic [OHMS_W-1:0] OHMS_MAX = 24'hFF_FFFF;

    typedef struct packed {
        logic [CODE_W-1:0] temp_code;
        logic [CODE_W-1:0] light_code;
    } sample_t;

    typedef struct packed {
        logic [TEMP_W-1:0] temperature;
        logic [OHMS_W-1:0] ldr_ohms;
        logic [LUX_W-1:0]  lux;
        logic              heater;
        logic              lamp;
    } result_t;

    function automatic logic [LUX_W-1:0] table_lux(input logic [3:0] idx);
        logic [LUX_W-1:0] v;
        case (idx)
            4'd0:    v = 10'd900;
            4'd1:    v = 10'd800;
            4'd2:    v = 10'd700;
            4'd3:    v = 10'd600;
            4'd4:    v = 10'd500;
            4'd5:    v = 10'd400;
            4'd6:    v = 10'd300;
            4'd7:    v = 10'd200;
            4'd8:    v = 10'd100;
            default: v = 10'd0;
        endcase
        return v;
    endfunction

    // Sum of the resistances of row idx and row idx+1. The table rises
    // strictly, so row idx+1 is nearer than row idx exactly when
    // 2*ohms exceeds this sum; an exact tie stays with the lower row.
    function automatic logic [20:0] table_pair_sum(input logic [3:0] idx);
        logic [20:0] v;
        case (idx)
            4'd0:    v = 21'd1500;
            4'd1:    v = 21'd3000;
            4'd2:    v = 21'd7000;
            4'd3:    v = 21'd15000;
            4'd4:    v = 21'd30000;
            4'd5:    v = 21'd70000;
            4'd6:    v = 21'd150000;
            4'd7:    v = 21'd300000;
            4'd8:    v = 21'd1200000;
            default: v = 21'h1F_FFFF;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/heater_lamp_hysteresis_controller_core.sv =====
// Top level of the heater and lamp hysteresis controller.
`timescale 1ns / 1ps

//  channel   direction  handshake                     payload
//  sample    in         sample_valid / sample_stall   temp_code, light_code
//  result    out        result_valid / result_stall   temperature, ldr_ohms, lux, heater, lamp
//  cfg       in         cfg_we                        cfg_index, cfg_data
//
//  From acceptance to the next acceptance an item passes through the bit-serial light
//  divider (the temperature divider runs alongside and ends first), forms the resistance,
//  walks the lux table, has its result registered and comes back to idle, where the next
//  item is taken.
//  Reset clears the control state and loads the register defaults.
//  A waiting result holds the block only in its final step, until the result is taken.

module heater_lamp_hysteresis_controller_core #(
    parameter int TABLE_ENTRIES = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  hlhc_pkg::sample_t                   sample,
    output logic                                result_valid,
    input  logic                                result_stall,
    output hlhc_pkg::result_t                   result,
    input  logic                                cfg_we,
    input  logic [hlhc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [hlhc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // Rows beyond the stored table are never searched.
    localparam int ENTRIES = (TABLE_ENTRIES < hlhc_pkg::TABLE_ROWS) ?
                             TABLE_ENTRIES : hlhc_pkg::TABLE_ROWS;
    localparam int IDX_W   = $clog2(ENTRIES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SCAN,
        S_DONE
    } state_t;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic                                auto_mode_reg;
    logic [hlhc_pkg::TEMP_W-1:0]         heat_on_below_reg;
    logic [hlhc_pkg::TEMP_W-1:0]         heat_off_above_reg;
    logic [hlhc_pkg::LUX_W-1:0]          lamp_on_below_reg;
    logic [hlhc_pkg::LUX_W-1:0]          lamp_off_above_reg;
    logic [hlhc_pkg::DIV_R_W-1:0]        divider_ohms_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_mode_reg      <= 1'b1;
            heat_on_below_reg  <= 9'd20;
            heat_off_above_reg <= 9'd24;
            lamp_on_below_reg  <= 10'd400;
            lamp_off_above_reg <= 10'd500;
            divider_ohms_reg   <= 16'd1000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hlhc_pkg::CFG_AUTO_MODE:      auto_mode_reg      <= cfg_data[0];
                hlhc_pkg::CFG_HEAT_ON_BELOW:  heat_on_below_reg  <= cfg_data[8:0];
                hlhc_pkg::CFG_HEAT_OFF_ABOVE: heat_off_above_reg <= cfg_data[8:0];
                hlhc_pkg::CFG_LAMP_ON_BELOW:  lamp_on_below_reg  <= cfg_data[9:0];
                hlhc_pkg::CFG_LAMP_OFF_ABOVE: lamp_off_above_reg <= cfg_data[9:0];
                hlhc_pkg::CFG_DIVIDER_OHMS:   divider_ohms_reg   <= cfg_data;
                default:                      ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Sequencer state and datapath registers
    // ---------------------------------------------------------------
    state_t                         state_reg;
    logic                           accept;
    logic                           result_load;
    logic                           lzero_reg;
    logic [hlhc_pkg::OHMS_W-1:0]    ohms_reg;
    logic [IDX_W-1:0]               best_reg;
    logic                           heater_reg;
    logic                           lamp_reg;
    logic                           result_valid_reg;
    hlhc_pkg::result_t              result_reg;

    assign sample_stall = (state_reg != S_IDLE);
    assign accept       = sample_valid && !sample_stall;
    // Load a finished item once the result register is free or being emptied.
    assign result_load  = (state_reg == S_DONE) && (!result_valid_reg || !result_stall);

    // ---------------------------------------------------------------
    // Dividers: code*330/4095 for temperature, divider*4095/code for light
    // ---------------------------------------------------------------
    logic [hlhc_pkg::TEMP_DIVIDEND_W-1:0]  temp_dividend;
    logic [hlhc_pkg::LIGHT_DIVIDEND_W-1:0] light_dividend;
    logic [hlhc_pkg::TEMP_DIVIDEND_W-1:0]  temp_quot;
    logic [hlhc_pkg::LIGHT_DIVIDEND_W-1:0] light_quot;
    logic                                  temp_busy;
    logic                                  light_busy;

    assign temp_dividend  = hlhc_pkg::TEMP_DIVIDEND_W'(sample.temp_code) *
                            hlhc_pkg::TEMP_DIVIDEND_W'(hlhc_pkg::TEMP_SCALE);
    // divider * 4095 as a shift and a subtract
    assign light_dividend = {divider_ohms_reg, 12'd0} -
                            hlhc_pkg::LIGHT_DIVIDEND_W'(divider_ohms_reg);

    hlhc_serial_div #(
        .DIVIDEND_W (hlhc_pkg::TEMP_DIVIDEND_W),
        .DIVISOR_W  (hlhc_pkg::CODE_W)
    ) u_temp_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .dividend (temp_dividend),
        .divisor  (hlhc_pkg::CODE_W'(hlhc_pkg::ADC_FULL)),
        .busy     (temp_busy),
        .quotient (temp_quot)
    );

    hlhc_serial_div #(
        .DIVIDEND_W (hlhc_pkg::LIGHT_DIVIDEND_W),
        .DIVISOR_W  (hlhc_pkg::CODE_W)
    ) u_light_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .dividend (light_dividend),
        .divisor  (sample.light_code),
        .busy     (light_busy),
        .quotient (light_quot)
    );

    // ---------------------------------------------------------------
    // Resistance: quotient minus divider, saturated; zero code saturates
    // ---------------------------------------------------------------
    logic [hlhc_pkg::LIGHT_DIVIDEND_W:0] ohms_diff;
    logic [hlhc_pkg::OHMS_W-1:0]         ohms_calc;

    assign ohms_diff = {1'b0, light_quot} -
                       (hlhc_pkg::LIGHT_DIVIDEND_W + 1)'(divider_ohms_reg);
    assign ohms_calc = (lzero_reg ||
                        (ohms_diff[hlhc_pkg::LIGHT_DIVIDEND_W:hlhc_pkg::OHMS_W] != '0)) ?
                       hlhc_pkg::OHMS_MAX : ohms_diff[hlhc_pkg::OHMS_W-1:0];

    // ---------------------------------------------------------------
    // Table walk: advance while the next row lies strictly nearer
    // ---------------------------------------------------------------
    logic [hlhc_pkg::OHMS_W:0] twice_ohms;
    logic                      step_up;

    assign twice_ohms = {ohms_reg, 1'b0};
    assign step_up    = (best_reg < IDX_W'(ENTRIES - 1)) &&
                        (twice_ohms > (hlhc_pkg::OHMS_W + 1)'(
                            hlhc_pkg::table_pair_sum(4'(best_reg))));

    // ---------------------------------------------------------------
    // Hysteresis: off condition applied last so it wins when both hold
    // ---------------------------------------------------------------
    logic [hlhc_pkg::TEMP_W-1:0] temperature;
    logic [hlhc_pkg::LUX_W-1:0]  lux;
    logic                        heater_next;
    logic                        lamp_next;

    assign temperature = temp_quot[hlhc_pkg::TEMP_W-1:0];
    assign lux         = hlhc_pkg::table_lux(4'(best_reg));

    always_comb
    begin
        heater_next = heater_reg;
        lamp_next   = lamp_reg;
        if (auto_mode_reg)
        begin
            if (temperature < heat_on_below_reg)
            begin
                heater_next = 1'b1;
            end
            if (temperature > heat_off_above_reg)
            begin
                heater_next = 1'b0;
            end
            if (lux < lamp_on_below_reg)
            begin
                lamp_next = 1'b1;
            end
            if (lux > lamp_off_above_reg)
            begin
                lamp_next = 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Sequencer and result register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            lzero_reg        <= 1'b0;
            ohms_reg         <= '0;
            best_reg         <= '0;
            heater_reg       <= 1'b0;
            lamp_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            // Raise valid as a new result loads; drop it once the far side takes it.
            if (result_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        lzero_reg <= (sample.light_code == '0);
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (!temp_busy && !light_busy)
                    begin
                        ohms_reg  <= ohms_calc;
                        best_reg  <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (step_up)
                    begin
                        best_reg <= best_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    // Hold here only while the previous result still waits.
                    if (result_load)
                    begin
                        heater_reg              <= heater_next;
                        lamp_reg                <= lamp_next;
                        result_reg.temperature  <= temperature;
                        result_reg.ldr_ohms     <= ohms_reg;
                        result_reg.lux          <= lux;
                        result_reg.heater       <= heater_next;
                        result_reg.lamp         <= lamp_next;
                        state_reg               <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== rtl/hlhc_serial_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module hlhc_serial_div #(
    parameter int DIVIDEND_W = 28,
    parameter int DIVISOR_W  = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [CNT_W-1:0]      count_reg;
    logic                  busy_reg;
    logic [DIVIDEND_W-1:0] shift_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  divisor_reg;

    logic [DIVISOR_W:0] trial;
    logic [DIVISOR_W:0] diff;
    logic               fits;

    // Bring down the next dividend bit and try the subtraction.
    assign trial = {rem_reg, shift_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, divisor_reg};
    assign fits  = (trial >= {1'b0, divisor_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            count_reg <= CNT_W'(DIVIDEND_W);
        end
        else if (busy_reg)
        begin
            count_reg <= count_reg - 1'b1;
            if (count_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Quotient bits enter at the bottom as dividend bits leave at the top.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg   <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg   <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            shift_reg <= {shift_reg[DIVIDEND_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign quotient = shift_reg;

endmodule

// ===== rtl/hlhc_checker.sv =====
// Port-level checker for the heater and lamp controller, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hlhc_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_valid,
    input  logic                              sample_stall,
    input  logic                              result_valid,
    input  logic                              result_stall,
    input  hlhc_pkg::result_t                 result
);

    logic sample_take;

    assign sample_take = sample_valid && !sample_stall;

    // A stalled result stays offered.
    `ASSERT_NEXT(a_result_holds, clk, rst_n, result_valid && result_stall, result_valid)

    // A stalled result keeps its value.
    `ASSERT_NEXT(a_result_stable, clk, rst_n, result_valid && result_stall, $stable(result))

    // Taking an item makes the block busy for the following cycle.
    `ASSERT_NEXT(a_busy_after_take, clk, rst_n, sample_take, sample_stall)

    // A fresh result only appears from a block that was busy with an item.
    `ASSERT_IMPL(a_result_from_work, clk, rst_n, $rose(result_valid), $past(sample_stall))

endmodule

bind heater_lamp_hysteresis_controller_core hlhc_checker u_hlhc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

// ===== bench/testbench.sv =====
// Self-checking testbench for the heater and lamp hysteresis controller core.
`timescale 1ns / 1ps

module testbench;

    // Table rows the block is built with, and the number of rows the
    // predictor searches.
    localparam int LUX_ROWS        = 10;
    // Settling time after the last result, kept well above the time one item takes.
    localparam int SETTLE_CYCLES   = 64;
    // Cycles without any handshake before the run is declared hung.
    localparam int WATCHDOG_LIMIT  = 3000;
    // Length of the long receiver hold-off in the back-pressure test.
    localparam int HOLDOFF_CYCLES  = 400;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int RANDOM_PHASES   = 7;

    // Register image, one field per configuration register.
    typedef struct packed {
        logic                         auto_on;
        logic [hlhc_pkg::TEMP_W-1:0]  heat_on_below;
        logic [hlhc_pkg::TEMP_W-1:0]  heat_off_above;
        logic [hlhc_pkg::LUX_W-1:0]   lamp_on_below;
        logic [hlhc_pkg::LUX_W-1:0]   lamp_off_above;
        logic [hlhc_pkg::DIV_R_W-1:0] divider;
    } settings_t;

    // Receiver behaviour between hold-offs.
    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    logic                             clk          = 1'b0;
    logic                             rst_n        = 1'b0;
    logic                             sample_valid = 1'b0;
    logic                             sample_stall;
    hlhc_pkg::sample_t                sample       = '0;
    logic                             result_valid;
    logic                             result_stall = 1'b0;
    hlhc_pkg::result_t                result;
    logic                             cfg_we       = 1'b0;
    logic [hlhc_pkg::CFG_INDEX_W-1:0] cfg_index    = hlhc_pkg::CFG_AUTO_MODE;
    logic [hlhc_pkg::CFG_DATA_W-1:0]  cfg_data     = '0;

    // Predictor state: register image and the two control flip-flops.
    settings_t   model_cfg;
    logic        model_heater;
    logic        model_lamp;

    // Readings predicted at acceptance, oldest first.
    hlhc_pkg::result_t expected_readings[$];

    int unsigned mismatches    = 0;
    int unsigned results_seen  = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned burst_left    = 0;
    int unsigned holdoff_cycles = 0;

    heater_lamp_hysteresis_controller_core #(
        .TABLE_ENTRIES (LUX_ROWS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic settings_t reset_settings();
        settings_t s;
        s.auto_on        = 1'b1;
        s.heat_on_below  = 9'd20;
        s.heat_off_above = 9'd24;
        s.lamp_on_below  = 10'd400;
        s.lamp_off_above = 10'd500;
        s.divider        = 16'd1000;
        return s;
    endfunction

    // Resistance of each calibration row; lux falls by 100 per row from 900.
    function automatic int unsigned row_ohms(input int unsigned row);
        int unsigned r;
        case (row)
            0:       r = 500;
            1:       r = 1000;
            2:       r = 2000;
            3:       r = 5000;
            4:       r = 10000;
            5:       r = 20000;
            6:       r = 50000;
            7:       r = 100000;
            8:       r = 200000;
            default: r = 1000000;
        endcase
        return r;
    endfunction

    // Work out the reading of one accepted item and advance the heater and
    // lamp state as the block does.
    function automatic hlhc_pkg::result_t predict_reading(input hlhc_pkg::sample_t s);
        hlhc_pkg::result_t r;
        int unsigned degrees;
        int unsigned product;
        int unsigned ohms;
        int unsigned best;
        int unsigned row;
        int unsigned gap_row;
        int unsigned gap_best;
        int unsigned lux;
        degrees = ((32'(s.temp_code) * 32'd3300) / 32'd4095) / 32'd10;
        if (s.light_code == '0)
        begin
            // No light code at all: the resistance pins at full scale.
            ohms = 32'(hlhc_pkg::OHMS_MAX);
        end
        else
        begin
            product = 32'(model_cfg.divider) * 32'd4095;
            ohms    = product / 32'(s.light_code) - 32'(model_cfg.divider);
            if (ohms > 32'(hlhc_pkg::OHMS_MAX))
                ohms = 32'(hlhc_pkg::OHMS_MAX);
        end
        // Nearest row wins; on a tie keep the lower row.
        best = 0;
        for (row = 1; row < LUX_ROWS; row++)
        begin
            gap_row  = row_ohms(row) > ohms ? row_ohms(row) - ohms : ohms - row_ohms(row);
            gap_best = row_ohms(best) > ohms ? row_ohms(best) - ohms
                                             : ohms - row_ohms(best);
            if (gap_row < gap_best)
                best = row;
        end
        lux = 900 - 100 * best;
        // Apply the switch-off condition last so that it wins when both hold.
        if (model_cfg.auto_on)
        begin
            if (degrees < 32'(model_cfg.heat_on_below))
                model_heater = 1'b1;
            if (degrees > 32'(model_cfg.heat_off_above))
                model_heater = 1'b0;
            if (lux < 32'(model_cfg.lamp_on_below))
                model_lamp = 1'b1;
            if (lux > 32'(model_cfg.lamp_off_above))
                model_lamp = 1'b0;
        end
        r.temperature = hlhc_pkg::TEMP_W'(degrees);
        r.ldr_ohms    = hlhc_pkg::OHMS_W'(ohms);
        r.lux         = hlhc_pkg::LUX_W'(lux);
        r.heater      = model_heater;
        r.lamp        = model_lamp;
        return r;
    endfunction

    // Track register writes and accepted items at the clock edge, in the
    // order the block sees them.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            model_cfg    = reset_settings();
            model_heater = 1'b0;
            model_lamp   = 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    hlhc_pkg::CFG_AUTO_MODE:
                        model_cfg.auto_on = cfg_data[0];
                    hlhc_pkg::CFG_HEAT_ON_BELOW:
                        model_cfg.heat_on_below = cfg_data[hlhc_pkg::TEMP_W-1:0];
                    hlhc_pkg::CFG_HEAT_OFF_ABOVE:
                        model_cfg.heat_off_above = cfg_data[hlhc_pkg::TEMP_W-1:0];
                    hlhc_pkg::CFG_LAMP_ON_BELOW:
                        model_cfg.lamp_on_below = cfg_data[hlhc_pkg::LUX_W-1:0];
                    hlhc_pkg::CFG_LAMP_OFF_ABOVE:
                        model_cfg.lamp_off_above = cfg_data[hlhc_pkg::LUX_W-1:0];
                    hlhc_pkg::CFG_DIVIDER_OHMS:
                        model_cfg.divider = cfg_data;
                    default: ;
                endcase
            end
            if (sample_valid && !sample_stall)
                expected_readings.push_back(predict_reading(sample));
        end
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Compare each accepted result with the oldest prediction, field by field.
    always @(posedge clk)
    begin : check_readings
        hlhc_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (expected_readings.size() == 0)
            begin
                report_mismatch($sformatf("result %0d arrived with nothing expected",
                                          results_seen));
            end
            else
            begin
                want = expected_readings.pop_front();
                if (result.temperature !== want.temperature)
                    report_mismatch($sformatf("result %0d temperature %0d, expected %0d",
                                              results_seen, result.temperature,
                                              want.temperature));
                if (result.ldr_ohms !== want.ldr_ohms)
                    report_mismatch($sformatf("result %0d ldr_ohms %0d, expected %0d",
                                              results_seen, result.ldr_ohms,
                                              want.ldr_ohms));
                if (result.lux !== want.lux)
                    report_mismatch($sformatf("result %0d lux %0d, expected %0d",
                                              results_seen, result.lux, want.lux));
                if (result.heater !== want.heater)
                    report_mismatch($sformatf("result %0d heater %b, expected %b",
                                              results_seen, result.heater, want.heater));
                if (result.lamp !== want.lamp)
                    report_mismatch($sformatf("result %0d lamp %b, expected %b",
                                              results_seen, result.lamp, want.lamp));
            end
        end
    end

    // Count cycles in which no handshake of any kind completes.
    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (sample_valid && !sample_stall)
                || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("** heater_lamp_hysteresis_controller_core: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: stall on a pattern of its own, and hold off on request
    // ------------------------------------------------------------------

    initial
    begin : result_receiver
        stall_mode_t mode;
        int unsigned mode_left;
        mode      = STALL_NONE;
        mode_left = 0;
        forever
        begin
            @(posedge clk);
            if (holdoff_cycles != 0)
            begin
                // Long hold-off: keep the result channel blocked so the block
                // fills up and pushes back on its input.
                result_stall <= 1'b1;
                repeat (holdoff_cycles) @(posedge clk);
                holdoff_cycles = 0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = stall_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(8, 160);
                end
                mode_left--;
                case (mode)
                    STALL_NONE:     result_stall <= 1'b0;
                    STALL_LIGHT:    result_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:    result_stall <= ($urandom_range(0, 3) != 0);
                    default:        result_stall <= ((mode_left % 5) < 2);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender and configuration helpers
    // ------------------------------------------------------------------

    // Offer one item and hold it until accepted. Items go out in bursts;
    // a new burst may start after a random gap with valid low.
    task automatic send_sample(input logic [hlhc_pkg::CODE_W-1:0] t_code,
                               input logic [hlhc_pkg::CODE_W-1:0] l_code);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 3))
                0:       gap = 0;
                1:       gap = $urandom_range(1, 3);
                2:       gap = $urandom_range(4, 20);
                default: gap = $urandom_range(21, 60);
            endcase
            if (gap != 0)
            begin
                sample_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        sample_valid <= 1'b1;
        sample       <= '{temp_code: t_code, light_code: l_code};
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
    endtask

    // Drop valid, wait for every prediction to be matched, then let the
    // block settle so that it is idle before the next register write.
    task automatic wait_for_results();
        sample_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input logic [hlhc_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [hlhc_pkg::CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // Write the whole register image, back to back.
    task automatic load_settings(input settings_t s);
        put_reg(hlhc_pkg::CFG_AUTO_MODE,      hlhc_pkg::CFG_DATA_W'(s.auto_on));
        put_reg(hlhc_pkg::CFG_HEAT_ON_BELOW,  hlhc_pkg::CFG_DATA_W'(s.heat_on_below));
        put_reg(hlhc_pkg::CFG_HEAT_OFF_ABOVE, hlhc_pkg::CFG_DATA_W'(s.heat_off_above));
        put_reg(hlhc_pkg::CFG_LAMP_ON_BELOW,  hlhc_pkg::CFG_DATA_W'(s.lamp_on_below));
        put_reg(hlhc_pkg::CFG_LAMP_OFF_ABOVE, hlhc_pkg::CFG_DATA_W'(s.lamp_off_above));
        put_reg(hlhc_pkg::CFG_DIVIDER_OHMS,   s.divider);
        cfg_we <= 1'b0;
    endtask

    // Random register image: mostly automatic mode with an ordinary band,
    // sometimes crossed thresholds, divider spread over small to full scale.
    function automatic settings_t random_settings();
        settings_t   s;
        int unsigned lo;
        int unsigned hi;
        s.auto_on = ($urandom_range(0, 7) != 0);
        lo = $urandom_range(0, 330);
        hi = lo + $urandom_range(0, 40);
        if (hi > 330)
            hi = 330;
        if ($urandom_range(0, 5) == 0)
        begin
            s.heat_on_below  = hlhc_pkg::TEMP_W'(hi);
            s.heat_off_above = hlhc_pkg::TEMP_W'(lo);
        end
        else
        begin
            s.heat_on_below  = hlhc_pkg::TEMP_W'(lo);
            s.heat_off_above = hlhc_pkg::TEMP_W'(hi);
        end
        lo = $urandom_range(0, 1023);
        hi = lo + $urandom_range(0, 250);
        if (hi > 1023)
            hi = 1023;
        if ($urandom_range(0, 5) == 0)
        begin
            s.lamp_on_below  = hlhc_pkg::LUX_W'(hi);
            s.lamp_off_above = hlhc_pkg::LUX_W'(lo);
        end
        else
        begin
            s.lamp_on_below  = hlhc_pkg::LUX_W'(lo);
            s.lamp_off_above = hlhc_pkg::LUX_W'(hi);
        end
        case ($urandom_range(0, 2))
            0:       s.divider = hlhc_pkg::DIV_R_W'($urandom_range(1, 300));
            1:       s.divider = hlhc_pkg::DIV_R_W'($urandom_range(300, 20000));
            default: s.divider = hlhc_pkg::DIV_R_W'($urandom_range(1, 65535));
        endcase
        return s;
    endfunction

    // Random item aimed at the interesting regions: temperatures around the
    // heater thresholds, light codes near the ends and around table rows.
    function automatic hlhc_pkg::sample_t random_sample(input settings_t cfg);
        hlhc_pkg::sample_t s;
        int unsigned       deg;
        longint unsigned   target;
        longint unsigned   code;
        case ($urandom_range(0, 2))
            0: s.temp_code = hlhc_pkg::CODE_W'($urandom_range(0, 4095));
            1:
            begin
                deg = $urandom_range(0, 1) ? 32'(cfg.heat_on_below)
                                           : 32'(cfg.heat_off_above);
                deg = deg + $urandom_range(0, 4);
                deg = deg > 2 ? deg - 2 : 0;
                code = longint'(deg) * 4095 / 330 + $urandom_range(0, 12);
                s.temp_code = hlhc_pkg::CODE_W'(code > 4095 ? 4095 : code);
            end
            default: s.temp_code = $urandom_range(0, 1) ?
                                   hlhc_pkg::CODE_W'(4095) :
                                   hlhc_pkg::CODE_W'($urandom_range(0, 15));
        endcase
        case ($urandom_range(0, 3))
            0: s.light_code = hlhc_pkg::CODE_W'($urandom_range(0, 4095));
            1: s.light_code = hlhc_pkg::CODE_W'($urandom_range(0, 63));
            2: s.light_code = hlhc_pkg::CODE_W'($urandom_range(4000, 4095));
            default:
            begin
                target = longint'(row_ohms($urandom_range(0, 9))) *
                         $urandom_range(50, 150) / 100;
                code   = longint'(cfg.divider) * 4095 / (target + cfg.divider);
                s.light_code = hlhc_pkg::CODE_W'(code > 4095 ? 4095 : code);
            end
        endcase
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values only: extremes, a temperature inside the band, and the
    // two table ties at 750 and 1500 ohms with the default divider.
    task automatic test_reset_defaults();
        send_sample(12'd0,    12'd0);
        send_sample(12'd273,  12'd2340);
        send_sample(12'd4095, 12'd1638);
        send_sample(12'd273,  12'd1);
        send_sample(12'hAAA,  12'h555);
        send_sample(12'h555,  12'hAAA);
        send_sample(12'd4095, 12'd4095);
        wait_for_results();
    endtask

    // Saturation with the largest divider, zero divider, smallest divider.
    task automatic test_divider_extremes();
        settings_t s;
        s = reset_settings();
        s.divider = 16'hFFFF;
        load_settings(s);
        send_sample(12'd0,    12'd1);
        send_sample(12'd4095, 12'd0);
        send_sample(12'd4095, 12'd4095);
        wait_for_results();
        s.divider = 16'd0;
        load_settings(s);
        send_sample(12'd100,  12'd0);
        send_sample(12'd100,  12'd1);
        send_sample(12'd100,  12'd4095);
        wait_for_results();
        s.divider = 16'd1;
        load_settings(s);
        send_sample(12'd0,    12'd1);
        send_sample(12'd0,    12'd4095);
        wait_for_results();
    endtask

    // Both on and off conditions true: switching off must win.
    task automatic test_crossed_thresholds();
        settings_t s;
        s = reset_settings();
        s.heat_on_below  = 9'd330;
        s.heat_off_above = 9'd0;
        s.lamp_on_below  = 10'd1023;
        s.lamp_off_above = 10'd0;
        load_settings(s);
        send_sample(12'd0,    12'd4095);
        send_sample(12'd40,   12'd1);
        send_sample(12'd4095, 12'd2340);
        wait_for_results();
    endtask

    // Manual mode: heater and lamp hold whatever the readings say.
    task automatic test_manual_hold();
        settings_t s;
        s = reset_settings();
        s.auto_on = 1'b0;
        load_settings(s);
        send_sample(12'd0,    12'd0);
        send_sample(12'd4095, 12'd4095);
        send_sample(12'd0,    12'd0);
        send_sample(12'd2000, 12'd1000);
        wait_for_results();
    endtask

    // Hold the receiver off for a long stretch while items keep coming.
    task automatic test_backpressure();
        settings_t         s;
        hlhc_pkg::sample_t item;
        s = random_settings();
        s.auto_on = 1'b1;
        load_settings(s);
        holdoff_cycles = HOLDOFF_CYCLES;
        repeat (30)
        begin
            item = random_sample(s);
            send_sample(item.temp_code, item.light_code);
        end
        wait_for_results();
    endtask

    // Random phases; the first two use the upper and lower register extremes.
    task automatic test_random_phases();
        settings_t         s;
        hlhc_pkg::sample_t item;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
                s = '{auto_on: 1'b1, heat_on_below: 9'd330, heat_off_above: 9'd330,
                      lamp_on_below: 10'd1023, lamp_off_above: 10'd1023,
                      divider: 16'hFFFF};
            else if (phase == 1)
                s = '{auto_on: 1'b1, heat_on_below: 9'd0, heat_off_above: 9'd0,
                      lamp_on_below: 10'd0, lamp_off_above: 10'd0, divider: 16'd1};
            else
                s = random_settings();
            load_settings(s);
            repeat (ITEMS_PER_PHASE)
            begin
                item = random_sample(s);
                send_sample(item.temp_code, item.light_code);
            end
            wait_for_results();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_divider_extremes();
        test_crossed_thresholds();
        test_manual_hold();
        test_backpressure();
        test_random_phases();

        if (expected_readings.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_readings.size()));

        if (mismatches == 0)
            $display("** heater_lamp_hysteresis_controller_core: PASSED **");
        else
            $display("** heater_lamp_hysteresis_controller_core: FAILED **");
        $finish;
    end

endmodule
